// File: rtl/core/rpt_pkg.sv
// Shared types, constants and the microprogram of the page table update engine.
package rpt_pkg;

	localparam int IDX_W   = 9;
	localparam int PPN_W   = 40;
	localparam int STEP_W  = 4;

	localparam logic [1:0] FUNC_MAP_KERNEL = 2'd0;
	localparam logic [1:0] FUNC_MAP_USER   = 2'd1;
	localparam logic [1:0] FUNC_UNMAP      = 2'd2;
	localparam logic [1:0] FUNC_PROTECT    = 2'd3;

	localparam logic [1:0] STATUS_DONE    = 2'd0;
	localparam logic [1:0] STATUS_MISSING = 2'd1;
	localparam logic [1:0] STATUS_FULL    = 2'd2;
	localparam logic [1:0] STATUS_RANGE   = 2'd3;

	localparam logic [63:0] PTE_KERNEL_DIR = 64'h3;

	localparam logic [1:0] LVL_PML4 = 2'd0;
	localparam logic [1:0] LVL_PDPT = 2'd1;
	localparam logic [1:0] LVL_PD   = 2'd2;
	localparam logic [1:0] LVL_PT   = 2'd3;

	localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
	localparam logic [STEP_W-1:0] STEP_READ      = 4'd1;
	localparam logic [STEP_W-1:0] STEP_TEST_LEAF = 4'd2;
	localparam logic [STEP_W-1:0] STEP_TEST_PRES = 4'd3;
	localparam logic [STEP_W-1:0] STEP_TEST_MAP  = 4'd4;
	localparam logic [STEP_W-1:0] STEP_TEST_FULL = 4'd5;
	localparam logic [STEP_W-1:0] STEP_ALLOC     = 4'd6;
	localparam logic [STEP_W-1:0] STEP_CLEAR     = 4'd7;
	localparam logic [STEP_W-1:0] STEP_LINK      = 4'd8;
	localparam logic [STEP_W-1:0] STEP_FOLLOW    = 4'd9;
	localparam logic [STEP_W-1:0] STEP_ADVANCE   = 4'd10;
	localparam logic [STEP_W-1:0] STEP_LEAF      = 4'd11;
	localparam logic [STEP_W-1:0] STEP_ERR_MISS  = 4'd12;
	localparam logic [STEP_W-1:0] STEP_ERR_FULL  = 4'd13;
	localparam logic [STEP_W-1:0] STEP_ERR_RANGE = 4'd14;
	localparam logic [STEP_W-1:0] STEP_FINISH    = 4'd15;

	typedef enum logic [3:0] {
		OP_NONE      = 4'd0,
		OP_LOAD      = 4'd1,
		OP_READ      = 4'd2,
		OP_ALLOC     = 4'd3,
		OP_CLEAR     = 4'd4,
		OP_LINK      = 4'd5,
		OP_ADVANCE   = 4'd6,
		OP_LEAF      = 4'd7,
		OP_ERR_MISS  = 4'd8,
		OP_ERR_FULL  = 4'd9,
		OP_ERR_RANGE = 4'd10,
		OP_FINISH    = 4'd11
	} op_t;

	typedef enum logic [3:0] {
		C_ALWAYS    = 4'd0,
		C_NO_ACCEPT = 4'd1,
		C_LVL3      = 4'd2,
		C_PRESENT   = 4'd3,
		C_NO_ALLOC  = 4'd4,
		C_POOL_FULL = 4'd5,
		C_CLEAN     = 4'd6,
		C_CLR_BUSY  = 4'd7,
		C_OUTSIDE   = 4'd8,
		C_OUT_BUSY  = 4'd9
	} cond_t;

	typedef struct packed {
		op_t               op;
		cond_t             cond;
		logic [STEP_W-1:0] target;
	} uc_word_t;

	typedef struct packed {
		logic no_accept;
		logic lvl3;
		logic present;
		logic no_alloc;
		logic pool_full;
		logic clean;
		logic clr_busy;
		logic outside;
		logic out_busy;
	} cond_flags_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] leaf;
		logic        inval;
	} result_t;

	// A taken condition jumps to the target, otherwise the step counter advances.
	function automatic uc_word_t uc_rom(input logic [STEP_W-1:0] step);
		uc_word_t w;
		unique case (step)
			STEP_IDLE:      w = '{OP_LOAD,      C_NO_ACCEPT, STEP_IDLE};
			STEP_READ:      w = '{OP_READ,      C_ALWAYS,    STEP_TEST_LEAF};
			STEP_TEST_LEAF: w = '{OP_NONE,      C_LVL3,      STEP_LEAF};
			STEP_TEST_PRES: w = '{OP_NONE,      C_PRESENT,   STEP_FOLLOW};
			STEP_TEST_MAP:  w = '{OP_NONE,      C_NO_ALLOC,  STEP_ERR_MISS};
			STEP_TEST_FULL: w = '{OP_NONE,      C_POOL_FULL, STEP_ERR_FULL};
			STEP_ALLOC:     w = '{OP_ALLOC,     C_CLEAN,     STEP_LINK};
			STEP_CLEAR:     w = '{OP_CLEAR,     C_CLR_BUSY,  STEP_CLEAR};
			STEP_LINK:      w = '{OP_LINK,      C_ALWAYS,    STEP_READ};
			STEP_FOLLOW:    w = '{OP_NONE,      C_OUTSIDE,   STEP_ERR_RANGE};
			STEP_ADVANCE:   w = '{OP_ADVANCE,   C_ALWAYS,    STEP_READ};
			STEP_LEAF:      w = '{OP_LEAF,      C_ALWAYS,    STEP_FINISH};
			STEP_ERR_MISS:  w = '{OP_ERR_MISS,  C_ALWAYS,    STEP_FINISH};
			STEP_ERR_FULL:  w = '{OP_ERR_FULL,  C_ALWAYS,    STEP_FINISH};
			STEP_ERR_RANGE: w = '{OP_ERR_RANGE, C_ALWAYS,    STEP_FINISH};
			STEP_FINISH:    w = '{OP_FINISH,    C_OUT_BUSY,  STEP_FINISH};
			default:        w = '{OP_NONE,      C_ALWAYS,    STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

// File: rtl/core/rpt_ucode_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
module rpt_ucode_seq
	import rpt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cond_flags_t flags,
	output op_t         op
);

	logic [STEP_W-1:0] step_q;
	uc_word_t          uword;
	logic              taken;

	assign uword = uc_rom(step_q);
	assign op    = uword.op;

	always_comb begin
		unique case (uword.cond)
			C_ALWAYS:    taken = 1'b1;
			C_NO_ACCEPT: taken = flags.no_accept;
			C_LVL3:      taken = flags.lvl3;
			C_PRESENT:   taken = flags.present;
			C_NO_ALLOC:  taken = flags.no_alloc;
			C_POOL_FULL: taken = flags.pool_full;
			C_CLEAN:     taken = flags.clean;
			C_CLR_BUSY:  taken = flags.clr_busy;
			C_OUTSIDE:   taken = flags.outside;
			C_OUT_BUSY:  taken = flags.out_busy;
			default:     taken = 1'b0;
		endcase
	end

	// The last step falls through to the first one when the counter wraps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else if (taken) begin
			step_q <= uword.target;
		end else begin
			step_q <= step_q + STEP_W'(1);
		end
	end

endmodule

// File: rtl/core/rpt_datapath.sv
// Walk datapath: request registers, table memory, bump allocator and condition flags.
module rpt_datapath
	import rpt_pkg::*;
#(
	parameter int TABLE_PAGES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  op_t         op,
	input  logic        accept,
	input  logic        out_busy,
	input  logic [1:0]  func,
	input  logic [47:0] virt_address,
	input  logic [51:0] phys_address,
	input  logic [63:0] entry_flags,
	input  logic        cfg_valid,
	input  logic [51:0] pool_base_address,
	output cond_flags_t flags,
	output result_t     res,
	output logic        init_busy
);

	localparam int PAGE_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
	localparam int NFP_W  = $clog2(TABLE_PAGES + 1);
	localparam int ADDR_W = PAGE_W + IDX_W;
	localparam int DEPTH  = TABLE_PAGES * (1 << IDX_W);

	logic [63:0]       table_mem [0:DEPTH-1];

	logic [PPN_W-1:0]  base_q;
	logic [NFP_W-1:0]  nfp_q;
	logic              dirty_q;
	logic              init_busy_q;
	logic [ADDR_W-1:0] init_addr_q;

	logic [1:0]        func_q;
	logic [47:0]       va_q;
	logic [51:0]       pa_q;
	logic [63:0]       flags_q;
	logic [PAGE_W-1:0] page_q;
	logic [PAGE_W-1:0] np_q;
	logic [1:0]        lvl_q;
	logic [IDX_W-1:0]  clr_q;
	logic [63:0]       rd_q;
	logic [1:0]        status_q;
	logic [63:0]       leaf_q;
	logic              inval_q;

	logic [IDX_W-1:0]  idx;
	logic [ADDR_W-1:0] slot_addr;
	logic [PPN_W-1:0]  off;
	logic              outside;
	logic [PPN_W-1:0]  new_ppn;
	logic [63:0]       mid_flags;
	logic [63:0]       link_val;
	logic [63:0]       leaf_val;
	logic              stray;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [63:0]       wdata;

	always_comb begin
		case (lvl_q)
			LVL_PML4: idx = va_q[47:39];
			LVL_PDPT: idx = va_q[38:30];
			LVL_PD:   idx = va_q[29:21];
			LVL_PT:   idx = va_q[20:12];
			default:  idx = va_q[20:12];
		endcase
	end

	assign slot_addr = {page_q, idx};

	// Offset of the pointed page from the pool base, in pages, modulo the address space.
	assign off     = rd_q[51:12] - base_q;
	assign outside = off >= PPN_W'(TABLE_PAGES);

	assign new_ppn   = base_q + PPN_W'(np_q);
	assign mid_flags = (func_q == FUNC_MAP_USER) ? flags_q : PTE_KERNEL_DIR;
	assign link_val  = {12'd0, new_ppn, 12'd0} | mid_flags;

	always_comb begin
		case (func_q)
			FUNC_MAP_KERNEL, FUNC_MAP_USER: leaf_val = {12'd0, pa_q} | flags_q;
			FUNC_UNMAP:                     leaf_val = 64'd0;
			default:                        leaf_val = {12'd0, rd_q[51:12], 12'd0} | flags_q;
		endcase
	end

	// A write into a page not yet handed out means later allocations must clear it.
	assign stray = NFP_W'(page_q) >= nfp_q;

	always_comb begin
		we    = 1'b0;
		waddr = slot_addr;
		wdata = 64'd0;
		if (init_busy_q) begin
			we    = 1'b1;
			waddr = init_addr_q;
		end else begin
			unique case (op)
				OP_CLEAR: begin
					we    = 1'b1;
					waddr = {np_q, clr_q};
				end
				OP_LINK: begin
					we    = 1'b1;
					wdata = link_val;
				end
				OP_LEAF: begin
					we    = 1'b1;
					wdata = leaf_val;
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			table_mem[waddr] <= wdata;
		end
		if (op == OP_READ) begin
			rd_q <= table_mem[slot_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			nfp_q       <= NFP_W'(1);
			dirty_q     <= 1'b0;
			init_busy_q <= 1'b1;
			init_addr_q <= '0;
		end else begin
			if (cfg_valid) begin
				base_q <= pool_base_address[51:12];
			end
			if (init_busy_q) begin
				init_addr_q <= init_addr_q + ADDR_W'(1);
				if (init_addr_q == ADDR_W'(DEPTH - 1)) begin
					init_busy_q <= 1'b0;
				end
			end
			if (op == OP_ALLOC) begin
				nfp_q <= nfp_q + NFP_W'(1);
			end
			if ((op == OP_LINK || op == OP_LEAF) && stray) begin
				dirty_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				if (accept) begin
					func_q   <= func;
					va_q     <= virt_address;
					pa_q     <= phys_address;
					flags_q  <= entry_flags;
					page_q   <= '0;
					lvl_q    <= LVL_PML4;
					status_q <= STATUS_DONE;
					leaf_q   <= 64'd0;
					inval_q  <= 1'b0;
				end
			end
			OP_ALLOC: begin
				np_q  <= nfp_q[PAGE_W-1:0];
				clr_q <= '0;
			end
			OP_CLEAR: begin
				clr_q <= clr_q + IDX_W'(1);
			end
			OP_LINK: begin
				page_q <= np_q;
				lvl_q  <= lvl_q + 2'd1;
			end
			OP_ADVANCE: begin
				page_q <= off[PAGE_W-1:0];
				lvl_q  <= lvl_q + 2'd1;
			end
			OP_LEAF: begin
				leaf_q  <= leaf_val;
				inval_q <= (func_q == FUNC_UNMAP);
			end
			OP_ERR_MISS: begin
				status_q <= STATUS_MISSING;
			end
			OP_ERR_FULL: begin
				status_q <= STATUS_FULL;
			end
			OP_ERR_RANGE: begin
				status_q <= STATUS_RANGE;
			end
			default: begin
			end
		endcase
	end

	assign flags.no_accept = !accept;
	assign flags.lvl3      = (lvl_q == LVL_PT);
	assign flags.present   = rd_q[0];
	assign flags.no_alloc  = (func_q == FUNC_UNMAP) || (func_q == FUNC_PROTECT);
	assign flags.pool_full = nfp_q >= NFP_W'(TABLE_PAGES);
	assign flags.clean     = !dirty_q;
	assign flags.clr_busy  = (clr_q != {IDX_W{1'b1}});
	assign flags.outside   = outside;
	assign flags.out_busy  = out_busy;

	assign res.status = status_q;
	assign res.leaf   = leaf_q;
	assign res.inval  = inval_q;
	assign init_busy  = init_busy_q;

endmodule

// File: rtl/core/radix_page_table_update_engine_core.sv
// Top level of the page table update engine: sequencer, datapath and result register.
// One item at a time. Each level of the walk reads its entry and either follows a present
// pointer or allocates a new page and links it; the next item is taken after the result.
// After a write has landed in a page not yet handed out, each allocation adds a
// clear of the whole new page through the table memory write port.
// After reset the table memory is swept to zero, with no item taken until the sweep ends.
module radix_page_table_update_engine_core
	import rpt_pkg::*;
#(
	parameter int TABLE_PAGES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [47:0] virt_address,
	input  logic [51:0] phys_address,
	input  logic [63:0] entry_flags,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [63:0] leaf_value,
	output logic        invalidate,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [51:0] pool_base_address
);

	op_t         op;
	cond_flags_t flags;
	result_t     res;
	logic        init_busy;
	logic        accept;
	logic        out_busy;
	logic        fire;
	logic        out_valid_q;
	result_t     out_q;

	assign in_ready  = (op == OP_LOAD) && !init_busy;
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_busy  = out_valid_q && !out_ready;
	assign fire      = (op == OP_FINISH) && !out_busy;

	rpt_ucode_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.op     (op)
	);

	rpt_datapath #(
		.TABLE_PAGES (TABLE_PAGES)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.op                (op),
		.accept            (accept),
		.out_busy          (out_busy),
		.func              (func),
		.virt_address      (virt_address),
		.phys_address      (phys_address),
		.entry_flags       (entry_flags),
		.cfg_valid         (cfg_valid),
		.pool_base_address (pool_base_address),
		.flags             (flags),
		.res               (res),
		.init_busy         (init_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_q.status;
	assign leaf_value = out_q.leaf;
	assign invalidate = out_q.inval;

`ifndef SYNTHESIS
	a_error_no_leaf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STATUS_DONE |-> leaf_value == 64'd0 && !invalidate)
		else $error("error result carries a leaf value or an invalidate");

	a_inval_unmap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && invalidate |-> status == STATUS_DONE && leaf_value == 64'd0)
		else $error("invalidate without a completed unmap");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("new item taken while a walk is in progress");
`endif

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the radix page table update engine core.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rpt_pkg::*;

	localparam int POOL_PAGES = 64;
	localparam int SLOTS = 512;
	localparam int REGIONS = 8;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned HOLD_CYCLES = 3000;
	localparam int unsigned SETTLE_CYCLES = 64;
	localparam logic [63:0] ADDR_MASK = 64'h000F_FFFF_FFFF_F000;
	localparam logic [63:0] OFF_MASK = 64'h000F_FFFF_FFFF_FFFF;

	typedef struct {
		logic [1:0]  func;
		logic [47:0] va;
		logic [51:0] pa;
		logic [63:0] flags;
		int unsigned gap;
	} pt_req_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  func = FUNC_MAP_KERNEL;
	logic [47:0] virt_address = '0;
	logic [51:0] phys_address = '0;
	logic [63:0] entry_flags = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [63:0] leaf_value;
	logic        invalidate;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [51:0] pool_base_address = '0;

	// Shadow of the page table pool and the allocator.
	logic [63:0] pt_store [POOL_PAGES * SLOTS];
	int unsigned free_page = 1;
	logic [63:0] pool_base_q = '0;

	pt_req_t update_reqs_q[$];
	result_t update_results_q[$];
	logic [47:0] region_va [REGIONS];

	int unsigned cycle_cnt = 0;
	int unsigned accepted_cnt = 0;
	int unsigned fail_cnt = 0;
	int unsigned cfg_cnt = 0;
	int unsigned inval_cnt = 0;
	int unsigned status_cnt [4] = '{0, 0, 0, 0};
	int unsigned hold_req = 0;
	int unsigned hold_taken = 0;
	int unsigned hold_left = 0;
	int unsigned rx_wait = 0;
	bit rx_calm = 1'b0;

	radix_page_table_update_engine_core #(
		.TABLE_PAGES(POOL_PAGES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.virt_address(virt_address),
		.phys_address(phys_address),
		.entry_flags(entry_flags),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.leaf_value(leaf_value),
		.invalidate(invalidate),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.pool_base_address(pool_base_address)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Walks the four levels of the shadow table and applies one request to it.
	task automatic apply_pt_update(input pt_req_t r, output result_t res);
		logic [63:0] dir_flags;
		logic [63:0] ent;
		logic [63:0] off;
		logic [1:0]  st;
		int unsigned page;
		int unsigned slot;
		int unsigned np;
		bit stop;
		res = '0;
		st = STATUS_DONE;
		page = 0;
		stop = 1'b0;
		dir_flags = (r.func == FUNC_MAP_USER) ? r.flags : PTE_KERNEL_DIR;
		for (int lvl = 0; lvl < 3 && !stop; lvl++) begin
			slot = page * SLOTS + int'((r.va >> (39 - 9 * lvl)) & 48'h1ff);
			ent = pt_store[slot];
			if (ent[0]) begin
				off = ((ent & ADDR_MASK) - pool_base_q) & OFF_MASK;
				if ((off >> 12) >= POOL_PAGES) begin
					st = STATUS_RANGE;
					stop = 1'b1;
				end else begin
					page = int'(off >> 12);
				end
			end else if (r.func == FUNC_MAP_KERNEL || r.func == FUNC_MAP_USER) begin
				if (free_page >= POOL_PAGES) begin
					st = STATUS_FULL;
					stop = 1'b1;
				end else begin
					np = free_page;
					free_page++;
					for (int k = 0; k < SLOTS; k++)
						pt_store[np * SLOTS + k] = '0;
					// The walk goes on into the new page even if the flags hide its address.
					pt_store[slot] = ((pool_base_q + (64'(np) << 12)) & ADDR_MASK) | dir_flags;
					page = np;
				end
			end else begin
				st = STATUS_MISSING;
				stop = 1'b1;
			end
		end
		if (st == STATUS_DONE) begin
			slot = page * SLOTS + int'(r.va[20:12]);
			case (r.func)
				FUNC_UNMAP: begin
					res.leaf = '0;
					res.inval = 1'b1;
				end
				FUNC_PROTECT: res.leaf = (pt_store[slot] & ADDR_MASK) | r.flags;
				default: res.leaf = {12'b0, r.pa} | r.flags;
			endcase
			pt_store[slot] = res.leaf;
		end
		res.status = st;
	endtask

	task automatic queue_item(input logic [1:0] f, input logic [47:0] va, input logic [51:0] pa,
			input logic [63:0] fl, input int unsigned gap);
		update_reqs_q.push_back('{f, va, pa, fl, gap});
	endtask

	task automatic queue_random(input int n, input bit no_gaps);
		logic [1:0]  f;
		logic [47:0] va;
		logic [63:0] fl;
		int pick;
		for (int i = 0; i < n; i++) begin
			f = 2'($urandom_range(0, 3));
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				va = 48'({$urandom, $urandom});
			end else begin
				// Most items stay in a few regions so the tree stays small and leaves are hit again.
				va = region_va[$urandom_range(0, REGIONS - 1)];
				va[20:12] = (pick < 30) ? 9'($urandom) : 9'($urandom_range(0, 15));
				va[11:0] = 12'($urandom);
			end
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				fl = {$urandom, $urandom};
			end else begin
				fl = {1'($urandom), 51'b0, 12'($urandom)};
				if (f == FUNC_MAP_USER && pick < 92)
					fl[0] = 1'b1;
			end
			queue_item(f, va, 52'({$urandom, $urandom}), fl, no_gaps ? 0 : $urandom_range(0, 11));
		end
	endtask

	task automatic write_pool_base(input logic [51:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		pool_base_address <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		pool_base_q = {12'b0, v[51:12], 12'b0};
		cfg_cnt++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (update_reqs_q.size() != 0 || in_valid || update_results_q.size() != 0);
	endtask

	always @(posedge clk) begin : item_drive
		logic nxt_valid;
		result_t want;
		static int unsigned gap_cnt = 0;
		static pt_req_t cur_req;
		nxt_valid = in_valid;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				apply_pt_update(cur_req, want);
				update_results_q.push_back(want);
				accepted_cnt++;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid && update_reqs_q.size() != 0) begin
				if (gap_cnt < update_reqs_q[0].gap) begin
					gap_cnt++;
				end else begin
					cur_req = update_reqs_q.pop_front();
					gap_cnt = 0;
					func <= cur_req.func;
					virt_address <= cur_req.va;
					phys_address <= cur_req.pa;
					entry_flags <= cur_req.flags;
					nxt_valid = 1'b1;
				end
			end
		end
		in_valid <= nxt_valid;
	end

	// Long receiver hold-off, so the engine sits on a finished result and stops taking items.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_taken != hold_req) begin
			hold_left <= HOLD_CYCLES;
			hold_taken <= hold_req;
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (out_valid && out_ready) begin
			if (update_results_q.size() == 0) begin
				fail_cnt++;
				$display("%0t: result with no item outstanding, status %0d leaf %h", $time,
					status, leaf_value);
			end else begin
				want = update_results_q.pop_front();
				status_cnt[want.status]++;
				if (want.inval)
					inval_cnt++;
				if (status !== want.status) begin
					fail_cnt++;
					$display("%0t: status expected %0d actual %0d", $time, want.status, status);
				end
				if (leaf_value !== want.leaf) begin
					fail_cnt++;
					$display("%0t: leaf_value expected %h actual %h", $time, want.leaf, leaf_value);
				end
				if (invalidate !== want.inval) begin
					fail_cnt++;
					$display("%0t: invalidate expected %0d actual %0d", $time, want.inval,
						invalidate);
				end
			end
			rx_wait = rx_calm ? 0 : $urandom_range(0, 11);
		end else if (out_valid && rx_wait != 0) begin
			rx_wait--;
		end
		out_ready <= (rx_wait == 0) && (hold_left == 0);
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		for (int k = 0; k < POOL_PAGES * SLOTS; k++)
			pt_store[k] = '0;
		region_va[0] = '0;
		region_va[1] = 48'hFFFF_FFE0_0000;
		for (int i = 2; i < REGIONS; i++) begin
			region_va[i] = 48'({$urandom, $urandom}) & 48'hFFFF_FFE0_0000;
			if (i < 5)
				region_va[i][47:39] = '0;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		write_pool_base(52'h0);
		queue_item(FUNC_MAP_KERNEL, 48'h0, 52'h1000, 64'h3, $urandom_range(0, 11));
		queue_item(FUNC_PROTECT, 48'h0, 52'h0, 64'h8000_0000_0000_0005, $urandom_range(0, 11));
		queue_item(FUNC_UNMAP, 48'h0, 52'h0, 64'h0, $urandom_range(0, 11));
		queue_item(FUNC_UNMAP, 48'h0, 52'h0, 64'h0, $urandom_range(0, 11));
		queue_item(FUNC_PROTECT, 48'hFFFF_FFFF_FFFF, 52'h0, 64'h3, $urandom_range(0, 11));
		queue_item(FUNC_UNMAP, 48'hFFFF_FFFF_FFFF, 52'h0, 64'h0, $urandom_range(0, 11));
		queue_item(FUNC_MAP_KERNEL, 48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, $urandom_range(0, 11));
		queue_item(FUNC_PROTECT, 48'hFFFF_FFFF_FFFF, 52'h0, 64'h0, $urandom_range(0, 11));
		queue_item(FUNC_MAP_USER, 48'h0000_4020_1000, 52'h2000, 64'h7, $urandom_range(0, 11));
		// User flags without the present bit leave the new levels looking absent.
		queue_item(FUNC_MAP_USER, 48'h0080_0000_0000, 52'h3000, 64'h6, $urandom_range(0, 11));
		queue_item(FUNC_MAP_USER, 48'h0080_0000_0000, 52'h3000, 64'h6, $urandom_range(0, 11));
		queue_item(FUNC_UNMAP, 48'h0080_0000_0000, 52'h0, 64'h0, $urandom_range(0, 11));
		// These flags move the stored pointers past the end of the pool.
		queue_item(FUNC_MAP_USER, 48'h0100_0000_0000, 52'h4000, 64'h0000_0000_0004_0007,
			$urandom_range(0, 11));
		queue_item(FUNC_PROTECT, 48'h0100_0000_0000, 52'h0, 64'h1, $urandom_range(0, 11));
		queue_item(FUNC_MAP_KERNEL, 48'h0100_0000_0000, 52'h5000, 64'h3, $urandom_range(0, 11));
		queue_item(FUNC_MAP_KERNEL, 48'h0000_001F_F000, 52'h7_5000, 64'h8000_0000_0000_0003,
			$urandom_range(0, 11));
		queue_item(FUNC_PROTECT, 48'h0000_001F_F000, 52'h0, 64'h7, $urandom_range(0, 11));
		queue_item(FUNC_MAP_KERNEL, 48'h0, 52'h1234_5678_9ABC, 64'h1, $urandom_range(0, 11));
		queue_random(450, 1'b0);
		do @(negedge clk); while (update_reqs_q.size() > 300);
		hold_req++;
		wait_drained();

		write_pool_base(52'hF_FFFF_FFFF_F000 | 52'($urandom_range(0, 4095)));
		queue_random(300, 1'b0);
		wait_drained();

		rx_calm = 1'b1;
		write_pool_base(52'({$urandom, $urandom}));
		queue_random(300, 1'b1);
		wait_drained();
		rx_calm = 1'b0;

		write_pool_base(52'h0);
		queue_random(450, 1'b0);
		do @(negedge clk); while (update_reqs_q.size() > 250);
		hold_req++;
		wait_drained();

		write_pool_base(52'($urandom_range(1, 80)) << 12);
		queue_random(300, 1'b0);
		wait_drained();

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Ran %0d table update items under %0d pool base settings, %0d invalidates.",
			accepted_cnt, cfg_cnt, inval_cnt);
		$display("Outcomes: %0d done, %0d missing level, %0d pool full, %0d outside pool.",
			status_cnt[STATUS_DONE], status_cnt[STATUS_MISSING], status_cnt[STATUS_FULL],
			status_cnt[STATUS_RANGE]);
		if (fail_cnt == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
